>>> rtl/core/mfwf_pkg.sv
// mfwf_pkg: shared constants, payload structs and state types of the
// most frequent word finder; no dependencies
package mfwf_pkg;

    localparam int MAX_WORDS  = 1024;
    localparam int MAX_CHARS  = 32;
    localparam int IDX_W      = $clog2(MAX_WORDS);
    localparam int CNT_W      = $clog2(MAX_WORDS) + 1;
    localparam int LEN_W      = $clog2(MAX_CHARS) + 1;
    localparam int CHAR_IDX_W = $clog2(MAX_CHARS);
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOW  = 2'd1;
    localparam logic [1:0] KIND_EOL  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       ch_res;
        logic [CNT_W-1:0] best_count;
        logic [CNT_W-1:0] total_words;
        logic [CNT_W-1:0] unique_words;
        logic             found;
        logic             truncated;
        logic             words_dropped;
        logic             last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_EOW,
        OP_EOL
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } op_item_t;

    // one table row: count, length and the characters of one distinct word
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        logic [LEN_W-1:0]                len;
        logic [MAX_CHARS-1:0][7:0]       chars;
    } row_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SRCH,
        B_CMP,
        B_FIN,
        B_LOAD,
        B_EMIT,
        B_EMPTY
    } back_state_t;

endpackage

>>> rtl/core/mfwf_front.sv
// mfwf_front: accepts input beats, decodes the kind and queues the ops
// depends on mfwf_pkg
module mfwf_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mfwf_pkg::in_item_t  s_data,
    output logic                q_valid,
    input  logic                q_pop,
    output mfwf_pkg::op_item_t  q_data
);
    import mfwf_pkg::*;

    op_item_t             q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]     cnt_reg, cnt_next;
    logic                 accept, push, pop;
    op_item_t             dec;

    // decode; unknown kind is dropped here
    always_comb begin
        dec.ch = s_data.ch;
        dec.op = OP_CHAR;
        push   = 1'b0;
        case (s_data.kind)
            KIND_CHAR: begin dec.op = OP_CHAR; push = accept; end
            KIND_EOW:  begin dec.op = OP_EOW;  push = accept; end
            KIND_EOL:  begin dec.op = OP_EOL;  push = accept; end
            default:   begin dec.op = OP_CHAR; push = 1'b0;   end
        endcase
    end

    assign s_ready = (cnt_reg != (Q_PTR_W+1)'(Q_DEPTH));
    assign accept  = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_data  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

>>> rtl/core/mfwf_back.sv
// mfwf_back: word buffer, word table walk, best tracking and result output
// depends on mfwf_pkg
module mfwf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_pop,
    input  mfwf_pkg::op_item_t  q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mfwf_pkg::out_item_t m_data
);
    import mfwf_pkg::*;

    row_t                       mem [MAX_WORDS];
    row_t                       rdata_reg;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    row_t                       wr_row;

    back_state_t                state_reg, state_next;
    logic [MAX_CHARS-1:0][7:0]  wbuf_reg;
    logic [LEN_W-1:0]           wlen_reg;
    logic [CNT_W-1:0]           total_reg, distinct_reg, best_cnt_reg;
    logic [IDX_W-1:0]           best_idx_reg;
    logic                       trunc_reg, drop_reg, eol_reg;
    logic [CNT_W-1:0]           idx_reg;
    logic [CHAR_IDX_W-1:0]      k_reg;
    logic                       m_valid_reg;
    out_item_t                  m_data_reg;

    logic                       slot_free, match, full, skip_close;
    logic [CNT_W-1:0]           new_cnt;
    logic                       better;
    logic                       emit_last;
    logic                       emit_fire;

    assign slot_free  = !m_valid_reg || m_ready;
    assign full       = (total_reg >= CNT_W'(MAX_WORDS));
    assign skip_close = (wlen_reg == '0) || full;
    assign emit_last  = ((LEN_W'(k_reg) + 1'b1) == rdata_reg.len);
    assign emit_fire  = slot_free && (state_reg inside {B_EMIT, B_EMPTY});

    // length and masked character compare against the buffered word
    always_comb begin
        match = (rdata_reg.len == wlen_reg);
        for (int b = 0; b < MAX_CHARS; b++) begin
            if ((LEN_W'(b) < wlen_reg) && (rdata_reg.chars[b] != wbuf_reg[b])) begin
                match = 1'b0;
            end
        end
    end

    // count after this word lands: hit bumps the stored count, miss starts at one
    always_comb begin
        new_cnt = (state_reg == B_CMP) ? rdata_reg.count + 1'b1 : CNT_W'(1);
        better  = (new_cnt > best_cnt_reg) ||
                  ((new_cnt == best_cnt_reg) && (idx_reg < CNT_W'(best_idx_reg)));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_valid && (q_data.op == OP_EOW || q_data.op == OP_EOL)) begin
                    if (!skip_close) begin
                        state_next = B_SRCH;
                    end else if (q_data.op == OP_EOL) begin
                        state_next = B_FIN;
                    end
                end
            end
            B_SRCH: begin
                if (idx_reg == distinct_reg) begin
                    state_next = eol_reg ? B_FIN : B_IDLE;
                end else begin
                    state_next = B_CMP;
                end
            end
            B_CMP: begin
                if (match) begin
                    state_next = eol_reg ? B_FIN : B_IDLE;
                end else begin
                    state_next = B_SRCH;
                end
            end
            B_FIN:   state_next = (total_reg == '0) ? B_EMPTY : B_LOAD;
            B_LOAD:  state_next = B_EMIT;
            B_EMIT: begin
                if (slot_free && emit_last) begin
                    state_next = B_IDLE;
                end
            end
            B_EMPTY: begin
                if (slot_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = idx_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_row.chars = wbuf_reg;
        wr_row.len   = wlen_reg;
        wr_row.count = new_cnt;
        case (state_reg)
            B_IDLE: q_pop = q_valid;
            B_SRCH: begin
                if (idx_reg == distinct_reg) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en = 1'b1;
                end
            end
            B_CMP:  wr_en = match;
            B_FIN: begin
                rd_en   = (total_reg != '0);
                rd_addr = best_idx_reg;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_data.op == OP_CHAR && wlen_reg < LEN_W'(MAX_CHARS)) begin
            wbuf_reg[wlen_reg[CHAR_IDX_W-1:0]] <= q_data.ch;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            wlen_reg     <= '0;
            total_reg    <= '0;
            distinct_reg <= '0;
            best_cnt_reg <= '0;
            best_idx_reg <= '0;
            trunc_reg    <= 1'b0;
            drop_reg     <= 1'b0;
            eol_reg      <= 1'b0;
            idx_reg      <= '0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    idx_reg <= '0;
                    if (q_valid) begin
                        eol_reg <= (q_data.op == OP_EOL);
                        if (q_data.op == OP_CHAR) begin
                            if (wlen_reg < LEN_W'(MAX_CHARS)) begin
                                wlen_reg <= wlen_reg + 1'b1;
                            end else begin
                                trunc_reg <= 1'b1;
                            end
                        end else if (wlen_reg != '0 && full) begin
                            drop_reg <= 1'b1;
                            wlen_reg <= '0;
                        end
                    end
                end
                B_SRCH: begin
                    if (idx_reg == distinct_reg) begin
                        distinct_reg <= distinct_reg + 1'b1;
                        total_reg    <= total_reg + 1'b1;
                        wlen_reg     <= '0;
                        if (better) begin
                            best_cnt_reg <= new_cnt;
                            best_idx_reg <= idx_reg[IDX_W-1:0];
                        end
                    end
                end
                B_CMP: begin
                    if (match) begin
                        total_reg <= total_reg + 1'b1;
                        wlen_reg  <= '0;
                        if (better) begin
                            best_cnt_reg <= new_cnt;
                            best_idx_reg <= idx_reg[IDX_W-1:0];
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                B_LOAD: k_reg <= '0;
                B_EMIT: begin
                    if (slot_free) begin
                        m_data_reg.ch_res          <= rdata_reg.chars[k_reg];
                        m_data_reg.best_count      <= best_cnt_reg;
                        m_data_reg.total_words     <= total_reg;
                        m_data_reg.unique_words    <= distinct_reg;
                        m_data_reg.found           <= 1'b1;
                        m_data_reg.truncated       <= trunc_reg;
                        m_data_reg.words_dropped   <= drop_reg;
                        m_data_reg.last            <= emit_last;
                        k_reg                      <= k_reg + 1'b1;
                        if (emit_last) begin
                            total_reg    <= '0;
                            distinct_reg <= '0;
                            best_cnt_reg <= '0;
                            best_idx_reg <= '0;
                            trunc_reg    <= 1'b0;
                            drop_reg     <= 1'b0;
                        end
                    end
                end
                B_EMPTY: begin
                    if (slot_free) begin
                        m_data_reg.ch_res          <= '0;
                        m_data_reg.best_count      <= '0;
                        m_data_reg.total_words     <= '0;
                        m_data_reg.unique_words    <= '0;
                        m_data_reg.found           <= 1'b0;
                        m_data_reg.truncated       <= trunc_reg;
                        m_data_reg.words_dropped   <= drop_reg;
                        m_data_reg.last            <= 1'b1;
                        trunc_reg                  <= 1'b0;
                        drop_reg                   <= 1'b0;
                    end
                end
                default: begin
                    eol_reg <= eol_reg;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/core/most_frequent_word_finder_unit.sv
// most_frequent_word_finder_unit: top level, front decode queue plus back
// table engine; depends on mfwf_pkg, mfwf_front, mfwf_back
//
//  channel   dir  handshake          beat payload
//  s_        in   s_valid/s_ready    in_item_t  {kind, ch}
//  m_        out  m_valid/m_ready    out_item_t {ch_res, counts, flags, last}
//
// the back end takes one character beat per cycle while idle; an end of
// word walks the stored entries one at a time, limited by the single read port of
// the word table, one row (count, length, all characters) per read
// end of list passes B_FIN, then B_LOAD and one beat per character, or one empty beat
// reset (aresetn low, synchronous) clears counters, flags and queue; the
// table needs no clearing since only rows below the distinct count are read
// a four-deep queue lets s_ keep filling while the table walk runs, and the
// output register lets the back end go on while a result beat waits
module most_frequent_word_finder_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mfwf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mfwf_pkg::out_item_t m_data
);
    import mfwf_pkg::*;

    // decoded ops between front and back
    logic     q_valid;
    logic     q_pop;
    op_item_t q_data;

    mfwf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    // table walk and result emission
    mfwf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/core/mfwf_checker.sv
// mfwf_checker: port-level assertions for the word finder, bound to the top
// depends on mfwf_pkg and most_frequent_word_finder_unit
module mfwf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mfwf_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input mfwf_pkg::out_item_t m_data
);
    import mfwf_pkg::*;

    // a stalled result beat stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped while stalled");

    // empty list gives one beat with zero counts
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.last && m_data.best_count == '0 &&
        m_data.total_words == '0 && m_data.unique_words == '0)
        else $error("empty list result malformed");

    // best count nonzero, best and distinct counts bounded by total, total by MAX_WORDS
    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.best_count != '0 &&
        m_data.best_count <= m_data.total_words &&
        m_data.unique_words <= m_data.total_words &&
        m_data.total_words <= CNT_W'(MAX_WORDS))
        else $error("result counts inconsistent");

    // beats of one word share the same best and total counts
    a_same: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last ##1 m_valid |->
        m_data.best_count == $past(m_data.best_count) &&
        m_data.total_words == $past(m_data.total_words))
        else $error("counts changed within one word");

endmodule

bind most_frequent_word_finder_unit mfwf_checker u_mfwf_checker (.*);
